// File: src/psd_pkg.sv
// Shared constants and types for the point-to-segment squared distance pipeline.
package psd_pkg;

  // Default coordinate width (signed fixed point, Q12.12 at this size).
  localparam int unsigned COORD_BITS_DEF = 24;

  // Result width (unsigned, twice the fraction bits of the inputs).
  localparam int unsigned DIST_W = 50;

  // Largest result; bigger values saturate here.
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Per-stage control that travels with each item.
  typedef struct packed {
    logic valid;
    logic use_div;  // middle case: subtract the projection term
  } psd_ctrl_t;

endpackage

// File: src/psd_dot.sv
// Front end: difference vectors, products, dot products and case selection.
module psd_dot import psd_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned MAG_W      = 2 * COORD_BITS + 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic signed [COORD_BITS-1:0] query_x_i,
  input  logic signed [COORD_BITS-1:0] query_y_i,
  input  logic signed [COORD_BITS-1:0] query_z_i,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] start_z_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  input  logic signed [COORD_BITS-1:0] end_z_i,
  output psd_ctrl_t                    ctrl_o,
  output logic        [MAG_W-1:0]      base_o,
  output logic        [MAG_W-1:0]      num_o,
  output logic        [MAG_W-1:0]      den_o
);

  localparam int unsigned DIFF_W = COORD_BITS + 1;
  localparam int unsigned PROD_W = 2 * DIFF_W;
  localparam int unsigned DOT_W  = MAG_W + 1;

  logic signed [COORD_BITS-1:0] pnt [3];
  logic signed [COORD_BITS-1:0] seg_a [3];
  logic signed [COORD_BITS-1:0] seg_b [3];

  assign pnt[0]   = query_x_i;
  assign pnt[1]   = query_y_i;
  assign pnt[2]   = query_z_i;
  assign seg_a[0] = start_x_i;
  assign seg_a[1] = start_y_i;
  assign seg_a[2] = start_z_i;
  assign seg_b[0] = end_x_i;
  assign seg_b[1] = end_y_i;
  assign seg_b[2] = end_z_i;

  logic [3:0] vld_q;

  // stage 1: differences
  logic signed [DIFF_W-1:0] v0_d [3], v1_d [3], v01_d [3];
  logic signed [DIFF_W-1:0] v0_q [3], v1_q [3], v01_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      v0_d[k]  = DIFF_W'(pnt[k])   - DIFF_W'(seg_a[k]);
      v1_d[k]  = DIFF_W'(pnt[k])   - DIFF_W'(seg_b[k]);
      v01_d[k] = DIFF_W'(seg_b[k]) - DIFF_W'(seg_a[k]);
    end
  end

  // stage 2: element products
  logic signed [PROD_W-1:0] p00_d [3], pa0_d [3], pb1_d [3], p11_d [3], pll_d [3];
  logic signed [PROD_W-1:0] p00_q [3], pa0_q [3], pb1_q [3], p11_q [3], pll_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p00_d[k] = v0_q[k]  * v0_q[k];
      pa0_d[k] = v0_q[k]  * v01_q[k];
      pb1_d[k] = v1_q[k]  * v01_q[k];
      p11_d[k] = v1_q[k]  * v1_q[k];
      pll_d[k] = v01_q[k] * v01_q[k];
    end
  end

  // stage 3: dot products
  logic signed [DOT_W-1:0] d00_d, a0_d, b1_d, d11_d, len2_d;
  logic signed [DOT_W-1:0] d00_q, a0_q, b1_q, d11_q, len2_q;

  always_comb begin
    d00_d  = DOT_W'(p00_q[0]) + DOT_W'(p00_q[1]) + DOT_W'(p00_q[2]);
    a0_d   = DOT_W'(pa0_q[0]) + DOT_W'(pa0_q[1]) + DOT_W'(pa0_q[2]);
    b1_d   = DOT_W'(pb1_q[0]) + DOT_W'(pb1_q[1]) + DOT_W'(pb1_q[2]);
    d11_d  = DOT_W'(p11_q[0]) + DOT_W'(p11_q[1]) + DOT_W'(p11_q[2]);
    len2_d = DOT_W'(pll_q[0]) + DOT_W'(pll_q[1]) + DOT_W'(pll_q[2]);
  end

  // stage 4: pick the closest feature
  logic             use_div_d, use_div_q;
  logic [MAG_W-1:0] base_d, base_q, num_q, den_q;

  always_comb begin
    base_d    = d00_q[MAG_W-1:0];
    use_div_d = 1'b0;
    if (a0_q[DOT_W-1]) begin
      base_d = d00_q[MAG_W-1:0];                        // before the start
    end else if (!b1_q[DOT_W-1] && (b1_q != '0)) begin
      base_d = d11_q[MAG_W-1:0];                        // past the end
    end else if (len2_q == '0) begin
      base_d = d00_q[MAG_W-1:0];                        // degenerate segment
    end else begin
      use_div_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v0_q      <= v0_d;
      v1_q      <= v1_d;
      v01_q     <= v01_d;
      p00_q     <= p00_d;
      pa0_q     <= pa0_d;
      pb1_q     <= pb1_d;
      p11_q     <= p11_d;
      pll_q     <= pll_d;
      d00_q     <= d00_d;
      a0_q      <= a0_d;
      b1_q      <= b1_d;
      d11_q     <= d11_d;
      len2_q    <= len2_d;
      use_div_q <= use_div_d;
      base_q    <= base_d;
      num_q     <= a0_q[MAG_W-1:0];
      den_q     <= len2_q[MAG_W-1:0];
    end
  end

  assign ctrl_o = '{valid: vld_q[3], use_div: use_div_q};
  assign base_o = base_q;
  assign num_o  = num_q;
  assign den_o  = den_q;

endmodule

// File: src/psd_sqdiv.sv
// Pipelined floor(num^2 / den): split squaring, then one quotient bit per stage.
module psd_sqdiv import psd_pkg::*; #(
  parameter int unsigned NUM_BITS = 2 * COORD_BITS_DEF + 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  psd_ctrl_t           ctrl_i,
  input  logic [NUM_BITS-1:0] base_i,
  input  logic [NUM_BITS-1:0] num_i,
  input  logic [NUM_BITS-1:0] den_i,
  output psd_ctrl_t           ctrl_o,
  output logic [NUM_BITS-1:0] base_o,
  output logic [NUM_BITS-1:0] quo_o
);

  localparam int unsigned HALF   = (NUM_BITS + 1) / 2;
  localparam int unsigned HI_W   = NUM_BITS - HALF;
  localparam int unsigned SQ_W   = 2 * NUM_BITS;
  localparam int unsigned STAGES = NUM_BITS + 2;

  // stage 0 = partial squares, stage 1 = full square, then NUM_BITS divide steps
  psd_ctrl_t           ctrl_q [STAGES];
  logic [NUM_BITS-1:0] base_q [STAGES];
  logic [NUM_BITS-1:0] den_q  [NUM_BITS+1];
  logic [NUM_BITS-1:0] rem_q  [NUM_BITS+1];
  logic [NUM_BITS-1:0] sh_q   [NUM_BITS+1];  // remaining dividend bits, quotient shifts in

  logic [HI_W-1:0]   num_hi;
  logic [HALF-1:0]   num_lo;
  logic [2*HI_W-1:0] hh_q;
  logic [NUM_BITS-1:0] hl_q;
  logic [2*HALF-1:0] ll_q;
  logic [SQ_W-1:0]   sq_d;

  assign num_hi = num_i[NUM_BITS-1:HALF];
  assign num_lo = num_i[HALF-1:0];

  assign sq_d = (SQ_W'(hh_q) << (2 * HALF)) + (SQ_W'(hl_q) << (HALF + 1)) + SQ_W'(ll_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < STAGES; s++) ctrl_q[s] <= '0;
    end else if (en_i) begin
      ctrl_q[0] <= ctrl_i;
      for (int s = 1; s < STAGES; s++) ctrl_q[s] <= ctrl_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hh_q      <= num_hi * num_hi;
      hl_q      <= num_hi * num_lo;
      ll_q      <= num_lo * num_lo;
      base_q[0] <= base_i;
      den_q[0]  <= den_i;
      for (int s = 1; s < STAGES; s++) base_q[s] <= base_q[s-1];
      for (int s = 1; s <= NUM_BITS; s++) den_q[s] <= den_q[s-1];
      // quotient fits in NUM_BITS, so the upper half is already below den
      rem_q[0] <= sq_d[SQ_W-1:NUM_BITS];
      sh_q[0]  <= sq_d[NUM_BITS-1:0];
    end
  end

  for (genvar j = 1; j <= NUM_BITS; j++) begin : g_step
    logic [NUM_BITS:0] trial;
    logic [NUM_BITS:0] diff;
    logic              take;

    assign trial = {rem_q[j-1], sh_q[j-1][NUM_BITS-1]};
    assign diff  = trial - {1'b0, den_q[j]};
    assign take  = !diff[NUM_BITS];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= take ? diff[NUM_BITS-1:0] : trial[NUM_BITS-1:0];
        sh_q[j]  <= {sh_q[j-1][NUM_BITS-2:0], take};
      end
    end
  end

  assign ctrl_o = ctrl_q[STAGES-1];
  assign base_o = base_q[STAGES-1];
  assign quo_o  = sh_q[NUM_BITS];

endmodule

// File: src/point_segment_squared_distance_top.sv
// Top level: squared distance from a 3D point to a segment, fully pipelined.
//
// Each transfer on the input carries a query point P and segment ends A (start)
// and B (end) as signed fixed point of COORD_BITS bits; a later transfer on the
// output carries the squared distance, unsigned, with twice the input fraction
// bits (Q12.12 in gives Q26.24 out at the default 24 bits). Closest point is A
// when the projection falls before A, B when it falls past B, otherwise the
// perpendicular foot: |P-A|^2 - floor(((P-A).(B-A))^2 / |B-A|^2), clamped at 0.
// A degenerate segment (A == B) gives |P-A|^2. Results above 2^50-1 saturate
// (only reachable with COORD_BITS above 24). The pipeline takes one item every
// cycle while it is not stalled. It has 4 stages for the difference vectors and
// dot products, 2 for the split squaring, one per quotient bit (2*COORD_BITS + 2)
// for the restoring divider and 1 for the final subtract and saturation into
// the output register. The whole pipeline advances together: while a result
// sits on the output and is stalled, the input is stalled in the same cycle;
// bubbles otherwise flow through freely. Results come out in input order. No
// configuration and no state beyond the pipeline; reset only clears the valid
// and control bits.
module point_segment_squared_distance_top import psd_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] query_x_i,
  input  logic signed [COORD_BITS-1:0] query_y_i,
  input  logic signed [COORD_BITS-1:0] query_z_i,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] start_z_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  input  logic signed [COORD_BITS-1:0] end_z_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic        [DIST_W-1:0]     dist_squared_o
);

  // magnitude width of any dot product in play
  localparam int unsigned MAG_W = 2 * COORD_BITS + 2;
  localparam int unsigned CMP_W = (MAG_W > DIST_W) ? MAG_W : DIST_W;

  // global advance: move when the output register is free or being drained
  logic en;
  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  psd_ctrl_t        dot_ctrl;
  logic [MAG_W-1:0] dot_base, dot_num, dot_den;

  psd_dot #(
    .COORD_BITS (COORD_BITS),
    .MAG_W      (MAG_W)
  ) u_dot (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (in_valid_i),
    .query_x_i (query_x_i),
    .query_y_i (query_y_i),
    .query_z_i (query_z_i),
    .start_x_i (start_x_i),
    .start_y_i (start_y_i),
    .start_z_i (start_z_i),
    .end_x_i   (end_x_i),
    .end_y_i   (end_y_i),
    .end_z_i   (end_z_i),
    .ctrl_o    (dot_ctrl),
    .base_o    (dot_base),
    .num_o     (dot_num),
    .den_o     (dot_den)
  );

  psd_ctrl_t        sd_ctrl;
  logic [MAG_W-1:0] sd_base, sd_quo;

  psd_sqdiv #(
    .NUM_BITS (MAG_W)
  ) u_sqdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctrl_i (dot_ctrl),
    .base_i (dot_base),
    .num_i  (dot_num),
    .den_i  (dot_den),
    .ctrl_o (sd_ctrl),
    .base_o (sd_base),
    .quo_o  (sd_quo)
  );

  // final stage: subtract the projection term, clamp at zero, saturate
  logic [MAG_W:0]      sub;
  logic [MAG_W-1:0]    val;
  logic [CMP_W-1:0]    val_ext;
  logic [DIST_W-1:0]   dist_d, dist_q;
  logic                out_valid_q;

  assign sub = {1'b0, sd_base} - {1'b0, sd_quo};

  always_comb begin
    if (sd_ctrl.use_div) begin
      val = sub[MAG_W] ? '0 : sub[MAG_W-1:0];
    end else begin
      val = sd_base;
    end
    val_ext = CMP_W'(val);
    if (val_ext > CMP_W'(DIST_MAX)) begin
      dist_d = DIST_MAX;
    end else begin
      dist_d = val_ext[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= sd_ctrl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_q <= dist_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign dist_squared_o = dist_q;

  // projection term never exceeds |P-A|^2 (Cauchy-Schwarz), so the clamp is a guard
  a_quo_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sd_ctrl.valid && sd_ctrl.use_div) |-> (sd_quo <= sd_base))
    else $error("divider quotient above base distance");

  // a held output must hold back the input in the same cycle
  a_stall_couples: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("input accepted while output stalled");

  // a result only appears when the last pipeline stage carried an item
  a_out_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(sd_ctrl.valid))
    else $error("output valid without a pipeline item");

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the point-to-segment squared distance pipeline.
`timescale 1ns / 1ps

module testbench;
  import psd_pkg::*;

  localparam int COORD_W = COORD_BITS_DEF;
  localparam int PIPE_LATENCY = 2 * COORD_W + 9;
  localparam int HOLD_CYCLES = 4 * PIPE_LATENCY;
  localparam int RANDOM_PER_PHASE = 511;
  localparam int CYCLE_LIMIT = 200000;
  localparam int NPROBES = 18;
  localparam int NPHASES = 3;
  localparam int MAX_REPORTS = 10;

  // Sender idle and receiver stall odds (percent) for each phase.
  localparam int SEND_IDLE [NPHASES] = '{29, 69, 0};
  localparam int RECV_STALL [NPHASES] = '{69, 29, 0};

  localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] C_MAX = ~C_MIN;
  localparam logic signed [COORD_W-1:0] ONE = COORD_W'(4096);  // 1.0 in Q12.12
  localparam logic signed [COORD_W-1:0] HALF = COORD_W'(2048);
  localparam logic signed [COORD_W-1:0] NEG_ONE = -COORD_W'(4096);

  // p: query point, s: segment start, e: segment end; index 0..2 is x, y, z
  typedef struct packed {
    logic [0:2][COORD_W-1:0] p;
    logic [0:2][COORD_W-1:0] s;
    logic [0:2][COORD_W-1:0] e;
  } seg_query_t;

  typedef struct packed {
    seg_query_t q;
    logic known;
    logic [DIST_W-1:0] want_dist;
  } probe_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [COORD_W-1:0] query_x_i = '0;
  logic signed [COORD_W-1:0] query_y_i = '0;
  logic signed [COORD_W-1:0] query_z_i = '0;
  logic signed [COORD_W-1:0] start_x_i = '0;
  logic signed [COORD_W-1:0] start_y_i = '0;
  logic signed [COORD_W-1:0] start_z_i = '0;
  logic signed [COORD_W-1:0] end_x_i = '0;
  logic signed [COORD_W-1:0] end_y_i = '0;
  logic signed [COORD_W-1:0] end_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [DIST_W-1:0] dist_squared_o;

  logic [DIST_W-1:0] pending_dist [$];
  logic [DIST_W-1:0] head_dist;
  int faults = 0;
  int cycle_count = 0;
  int idle_in_pct = 0;
  int stall_out_pct = 0;
  int phase = -1;
  logic hold_off = 1'b0;

  // Directed probes; rows with known set carry a hand-derived distance.
  probe_t probes [NPROBES] = '{
    // all zero: degenerate, zero distance
    '{'{'{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}}, 1'b1, 50'd0},
    // degenerate segment at origin, point at x = 1.0
    '{'{'{ONE, 0, 0}, '{0, 0, 0}, '{0, 0, 0}}, 1'b1, 50'd16777216},
    // degenerate, point and segment at opposite corners
    '{'{'{C_MAX, C_MAX, C_MAX}, '{C_MIN, C_MIN, C_MIN}, '{C_MIN, C_MIN, C_MIN}},
      1'b1, 50'd844424829468675},
    // projection before the start
    '{'{'{NEG_ONE, 0, 0}, '{0, 0, 0}, '{ONE, 0, 0}}, 1'b1, 50'd16777216},
    // projection past the end
    '{'{'{3 * ONE, 0, 0}, '{0, 0, 0}, '{ONE, 0, 0}}, 1'b1, 50'd67108864},
    // perpendicular foot inside the segment
    '{'{'{HALF, ONE, 0}, '{0, 0, 0}, '{ONE, 0, 0}}, 1'b1, 50'd16777216},
    // point on the segment
    '{'{'{HALF, 0, 0}, '{0, 0, 0}, '{ONE, 0, 0}}, 1'b1, 50'd0},
    // foot in the middle of a z-axis segment
    '{'{'{0, ONE, 0}, '{0, 0, NEG_ONE}, '{0, 0, ONE}}, 1'b1, 50'd16777216},
    // longest segment, point at origin
    '{'{'{0, 0, 0}, '{C_MIN, C_MIN, C_MIN}, '{C_MAX, C_MAX, C_MAX}}, 1'b0, 50'd0},
    // point equal to the end, reversed long segment
    '{'{'{C_MIN, C_MIN, C_MIN}, '{C_MAX, C_MAX, C_MAX}, '{C_MIN, C_MIN, C_MIN}},
      1'b1, 50'd0},
    // point equal to the end, long segment
    '{'{'{C_MAX, C_MAX, C_MAX}, '{C_MIN, C_MIN, C_MIN}, '{C_MAX, C_MAX, C_MAX}},
      1'b1, 50'd0},
    // mixed extremes
    '{'{'{C_MAX, C_MIN, C_MAX}, '{C_MIN, C_MAX, 0}, '{C_MAX, C_MIN, C_MIN}},
      1'b0, 50'd0},
    // tiny values, quotient truncation
    '{'{'{1, 1, 0}, '{0, 0, 0}, '{3, 1, 0}}, 1'b0, 50'd0},
    // degenerate at origin, point at the most negative corner
    '{'{'{C_MIN, C_MIN, C_MIN}, '{0, 0, 0}, '{0, 0, 0}}, 1'b1, 50'd211106232532992},
    // odd small values
    '{'{'{5, -7, 3}, '{1, 2, -4}, '{-6, 9, 11}}, 1'b0, 50'd0},
    // degenerate, one LSB per axis away in each direction
    '{'{'{-1, -1, -1}, '{1, 1, 1}, '{1, 1, 1}}, 1'b1, 50'd12},
    // far before the start
    '{'{'{C_MIN, 0, 0}, '{0, 0, 0}, '{C_MAX, 0, 0}}, 1'b1, 50'd70368744177664},
    // far past the end
    '{'{'{C_MAX, 0, 0}, '{C_MIN, 0, 0}, '{0, 0, 0}}, 1'b1, 50'd70368727400449}
  };

  point_segment_squared_distance_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .query_x_i      (query_x_i),
    .query_y_i      (query_y_i),
    .query_z_i      (query_z_i),
    .start_x_i      (start_x_i),
    .start_y_i      (start_y_i),
    .start_z_i      (start_z_i),
    .end_x_i        (end_x_i),
    .end_y_i        (end_y_i),
    .end_z_i        (end_z_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .dist_squared_o (dist_squared_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Exact squared distance; dot products in 64 bits, quotient in 128 bits.
  function automatic logic [DIST_W-1:0] seg_dist_sq(seg_query_t q);
    longint to_start [3];
    longint to_end [3];
    longint seg [3];
    longint d_start, d_end, proj_start, proj_end, len_sq;
    logic [127:0] quo, rem;
    int k;
    d_start = 0;
    d_end = 0;
    proj_start = 0;
    proj_end = 0;
    len_sq = 0;
    for (k = 0; k < 3; k++) begin
      to_start[k] = longint'($signed(q.p[k])) - longint'($signed(q.s[k]));
      to_end[k] = longint'($signed(q.p[k])) - longint'($signed(q.e[k]));
      seg[k] = longint'($signed(q.e[k])) - longint'($signed(q.s[k]));
      d_start += to_start[k] * to_start[k];
      d_end += to_end[k] * to_end[k];
      proj_start += to_start[k] * seg[k];
      proj_end -= to_end[k] * seg[k];
      len_sq += seg[k] * seg[k];
    end
    if (proj_start < 0) begin
      rem = 128'(d_start);
    end else if (proj_end < 0) begin
      rem = 128'(d_end);
    end else if (len_sq == 0) begin
      rem = 128'(d_start);
    end else begin
      quo = (128'(proj_start) * 128'(proj_start)) / 128'(len_sq);
      rem = (128'(d_start) >= quo) ? 128'(d_start) - quo : '0;
    end
    return (rem > 128'(DIST_MAX)) ? DIST_MAX : rem[DIST_W-1:0];
  endfunction

  // Signed value spread over the given number of bits.
  function automatic logic signed [COORD_W-1:0] rand_coord(int bits);
    return COORD_W'($signed($urandom) >>> (32 - bits));
  endfunction

  // Mix of full-range noise, projections onto the segment, degenerate
  // segments, tiny values and points sitting on an end.
  function automatic seg_query_t random_query();
    seg_query_t q;
    int mode, t, k, a, b;
    mode = $urandom_range(0, 9);
    for (k = 0; k < 3; k++) begin
      q.p[k] = rand_coord(24);
      q.s[k] = rand_coord(24);
      q.e[k] = rand_coord(24);
    end
    case (mode)
      3, 4, 5: begin
        t = $urandom_range(0, 256);
        for (k = 0; k < 3; k++) begin
          a = rand_coord(21);
          b = rand_coord(21);
          q.s[k] = COORD_W'(a);
          q.e[k] = COORD_W'(b);
          q.p[k] = COORD_W'(a + ((b - a) * t) / 256 + rand_coord(16));
        end
      end
      6: q.e = q.s;
      7, 8: begin
        for (k = 0; k < 3; k++) begin
          q.p[k] = rand_coord(7);
          q.s[k] = rand_coord(7);
          q.e[k] = rand_coord(7);
        end
      end
      9: begin
        if ($urandom_range(0, 1) == 1) q.p = q.s;
        else q.p = q.e;
      end
      default: ;
    endcase
    return q;
  endfunction

  task automatic note_fault(string what, logic [DIST_W-1:0] want, logic [DIST_W-1:0] got);
    faults++;
    if (faults <= MAX_REPORTS) begin
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    end
  endtask

  // Offer one query, hold it until the transfer, then log its distance.
  task automatic send_query(seg_query_t q, logic known, logic [DIST_W-1:0] want);
    logic took;
    while ($urandom_range(0, 99) < idle_in_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    query_x_i <= q.p[0];
    query_y_i <= q.p[1];
    query_z_i <= q.p[2];
    start_x_i <= q.s[0];
    start_y_i <= q.s[1];
    start_z_i <= q.s[2];
    end_x_i <= q.e[0];
    end_y_i <= q.e[1];
    end_z_i <= q.e[2];
    do begin
      @(negedge clk_i);
      took = !in_stall_o;
      @(posedge clk_i);
    end while (!took);
    pending_dist.push_back(known ? want : seg_dist_sq(q));
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= hold_off || ($urandom_range(0, 99) < stall_out_pct);
  end

  // Long output hold-off once idling stops, so the pipeline fills and backs up.
  initial begin
    wait (phase == NPHASES - 1);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Outputs are stable mid-cycle; a transfer happens at the next rising edge.
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_dist.size() == 0) begin
        note_fault("unexpected result", '0, dist_squared_o);
      end else begin
        head_dist = pending_dist.pop_front();
        if (dist_squared_o !== head_dist) note_fault("dist_squared", head_dist, dist_squared_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    int i, n;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (i = 0; i < NPHASES; i++) begin
      idle_in_pct = SEND_IDLE[i];
      stall_out_pct = RECV_STALL[i];
      phase = i;
      if (i == 0) begin
        for (n = 0; n < NPROBES; n++) begin
          send_query(probes[n].q, probes[n].known, probes[n].want_dist);
        end
      end
      for (n = 0; n < RANDOM_PER_PHASE; n++) send_query(random_query(), 1'b0, '0);
    end
    in_valid_i <= 1'b0;
    while (pending_dist.size() != 0) @(posedge clk_i);
    // anything arriving now is a spurious result
    repeat (2 * PIPE_LATENCY) @(posedge clk_i);
    if (pending_dist.size() != 0) begin
      note_fault("missing result", pending_dist[0], '0);
      faults += pending_dist.size() - 1;
    end
    if (faults == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
